// ----- rtl/bsvm_pkg.sv -----
// Shared types and constants for the blend shape vertex morph block.
`timescale 1ns / 1ps

package bsvm_pkg;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_FRAME = 2'd1;
    localparam logic [1:0] OP_APPLY = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [1:0] MARK_ORIG_ALL = 2'd0;
    localparam logic [1:0] MARK_ORIG_CUR = 2'd1;
    localparam logic [1:0] MARK_MODIFIED = 2'd2;

    localparam logic [3:0] ATTR_RESET = 4'hF;

    // Vertex word: color[159:128] uv[127:96] normal[95:48] position[47:0]
    localparam int VWORD_W = 160;

    // Lanes 0..7 are the 16-bit vector components, 8..11 the color bytes
    localparam logic [3:0] LANE_NORM_FIRST  = 4'd3;
    localparam logic [3:0] LANE_UV_FIRST    = 4'd6;
    localparam logic [3:0] LANE_COLOR_FIRST = 4'd8;
    localparam logic [3:0] LANE_LAST        = 4'd11;

    // x / 12800 = (x >> 9) / 25 ; x / 3276800 = (x >> 17) / 25
    localparam logic [22:0]        RECIP_25    = 23'd5368710;
    localparam int                 RECIP_SHIFT = 27;
    localparam logic [31:0]        VEC_HALF    = 32'd6400;
    localparam int                 VEC_SHIFT   = 9;
    localparam logic signed [32:0] COL_HALF    = 33'sd1638400;
    localparam int                 COL_SHIFT   = 17;
    localparam logic signed [22:0] COL_BIAS_U  = 23'sd409600;
    localparam logic signed [19:0] COL_BIAS_Q  = 20'sd16384;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD_WR,
        S_FRAME_RD,
        S_FRAME_WR,
        S_APPLY_RD,
        S_APPLY_LD,
        S_APPLY_LANE,
        S_APPLY_WR,
        S_READ_RD,
        S_READ_OUT
    } state_t;

    typedef struct packed {
        logic        start;
        logic        is_color;
        logic [15:0] cur;
        logic [15:0] delta;
    } lane_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] result;
    } lane_rsp_t;

endpackage

// ----- rtl/bsvm_lane_unit.sv -----
// Shared three-stage blend unit: one component or color byte per request.
`timescale 1ns / 1ps

module bsvm_lane_unit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  bsvm_pkg::lane_req_t      req,
    input  logic signed [15:0]       weight,
    output bsvm_pkg::lane_rsp_t      rsp
);
    import bsvm_pkg::*;

    logic               v1_reg, v2_reg, v3_reg;
    logic signed [31:0] p_reg;
    logic               col1_reg, col2_reg;
    logic [15:0]        cur1_reg, cur2_reg;
    logic               neg2_reg;
    logic [44:0]        prod_reg;
    logic [15:0]        res_reg;

    logic [30:0]        mag;
    logic [21:0]        u_vec, u_col, u_sel;
    logic signed [32:0] t_col;
    logic [15:0]        y_col;
    logic signed [22:0] u_col_s;
    logic [17:0]        q;
    logic signed [19:0] qs, s_vec, s_col;
    logic [15:0]        res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= req.start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage 2: magnitude or floor offset, then reciprocal multiply by 1/25
    always_comb
    begin
        mag     = p_reg[31] ? 31'(-p_reg) : 31'(p_reg);
        u_vec   = 22'((32'(mag) + VEC_HALF) >> VEC_SHIFT);
        t_col   = 33'(p_reg) + COL_HALF;
        y_col   = 16'(t_col >>> COL_SHIFT);
        u_col_s = 23'($signed(y_col)) + COL_BIAS_U;
        u_col   = u_col_s[21:0];
        u_sel   = col1_reg ? u_col : u_vec;
    end

    // stage 3: apply sign or bias, add to the current value, saturate
    always_comb
    begin
        q     = prod_reg[44:RECIP_SHIFT];
        qs    = $signed({2'b00, q});
        s_vec = 20'($signed(cur2_reg)) + (neg2_reg ? -qs : qs);
        s_col = $signed({12'd0, cur2_reg[7:0]}) + qs - COL_BIAS_Q;
        if (col2_reg)
        begin
            if (s_col < 20'sd0)
                res_next = 16'd0;
            else if (s_col > 20'sd255)
                res_next = 16'd255;
            else
                res_next = 16'(s_col);
        end
        else
        begin
            if (s_vec > 20'sd32767)
                res_next = 16'h7FFF;
            else if (s_vec < -20'sd32768)
                res_next = 16'h8000;
            else
                res_next = 16'(s_vec);
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= $signed(req.delta) * weight;
        col1_reg <= req.is_color;
        cur1_reg <= req.cur;
        prod_reg <= 45'(u_sel) * 45'(RECIP_25);
        neg2_reg <= p_reg[31];
        col2_reg <= col1_reg;
        cur2_reg <= cur1_reg;
        res_reg  <= res_next;
    end

    assign rsp.done   = v3_reg;
    assign rsp.result = res_reg;

endmodule

// ----- rtl/blend_shape_vertex_morph.sv -----
// Top level: vertex stores, operation sequencer, config register and result register.
`timescale 1ns / 1ps

// Morph target blender over VERTEX_COUNT vertices.
// Request channel (in_valid/in_ready) carries op, vertex_index, weight_percent,
// the packed attribute values and present_mask. Only a read request returns a
// result on the out_valid/out_ready channel; the others update the stores.
// attribute_enable sits at APB address 0 and is written while the block idles;
// the user is bound to this; the block does not enforce it. One request is worked
// at a time; in_ready is low until it finishes. The single-port stores and the
// shared blend unit shape each request: a load writes the stores; a read reads them,
// then waits for any previous result to leave; an apply with nonzero weight reads
// the stores, passes all 12 lanes one at a time through the blend unit, then writes
// back; a zero weight or bad index returns straight to idle; begin frame takes one
// read and one write step per vertex. After reset a clearing pass marks every
// vertex as modified; requests wait, config writes are taken.
// A stalled result is held in the output register; a following read request
// waits for it to be taken, other requests proceed.
module blend_shape_vertex_morph #(
    parameter int VERTEX_COUNT = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic [9:0]         vertex_index,
    input  logic signed [15:0] weight_percent,
    input  logic [47:0]        pos_value,
    input  logic [47:0]        norm_value,
    input  logic [31:0]        uv_value,
    input  logic [63:0]        color_value,
    input  logic [3:0]         present_mask,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [9:0]         out_vertex,
    output logic [47:0]        out_position,
    output logic [47:0]        out_normal,
    output logic [31:0]        out_uv,
    output logic [31:0]        out_color,
    output logic               needs_copy
);
    import bsvm_pkg::*;

    localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(VERTEX_COUNT - 1);

    state_t state_reg, state_next;

    logic [3:0]  attr_reg, attr_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [3:0]  lane_reg, lane_next;
    logic        busy_reg, busy_next;
    logic        out_valid_reg, out_valid_next;

    logic [1:0]         op_reg;
    logic [9:0]         vidx_reg;
    logic [AW-1:0]      idx_reg;
    logic signed [15:0] w_reg;
    logic [127:0]       vdelta_reg;
    logic [63:0]        col_reg;
    logic [3:0]         pm_reg;
    logic [VWORD_W-1:0] work_reg;

    logic [VWORD_W-1:0] orig_mem [VERTEX_COUNT];
    logic [VWORD_W-1:0] cur_mem  [VERTEX_COUNT];
    logic [1:0]         mark_mem [VERTEX_COUNT];
    logic [VWORD_W-1:0] orig_rd_reg, cur_rd_reg;
    logic [1:0]         mark_rd_reg;

    logic [9:0]  out_vertex_reg;
    logic [47:0] out_pos_reg, out_norm_reg;
    logic [31:0] out_uv_reg, out_col_reg;
    logic        needs_copy_reg;

    logic          accept, in_range, sweep, last_addr, out_load, lane_active;
    logic [16:0]   idx_ext;
    logic [AW-1:0] addr;
    logic          orig_we, cur_we, mark_we;
    logic [VWORD_W-1:0] cur_wdata;
    logic [1:0]    mark_wdata;
    logic [3:0]    act;
    lane_req_t     lane_req;
    lane_rsp_t     lane_rsp;

    assign idx_ext   = 17'(vertex_index);
    assign in_range  = idx_ext < 17'(VERTEX_COUNT);
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign sweep     = (state_reg == S_CLEAR) || (state_reg == S_FRAME_RD) ||
                       (state_reg == S_FRAME_WR);
    assign addr      = sweep ? cnt_reg : idx_reg;
    assign last_addr = (cnt_reg == LAST_ADDR);
    assign out_load  = (state_reg == S_READ_OUT) && (!out_valid_reg || out_ready);
    assign act       = attr_reg & pm_reg;

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {28'd0, attr_reg} : 32'd0;

    always_comb
    begin
        attr_next = attr_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == 1'b0))
            attr_next = pwdata[3:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
                if (last_addr)
                    state_next = S_IDLE;
            S_IDLE:
                if (in_valid)
                begin
                    case (op)
                        OP_FRAME: state_next = S_FRAME_RD;
                        OP_LOAD:  state_next = in_range ? S_LOAD_WR : S_IDLE;
                        OP_APPLY: state_next = (in_range && weight_percent != 16'sd0) ?
                                               S_APPLY_RD : S_IDLE;
                        OP_READ:  state_next = in_range ? S_READ_RD : S_IDLE;
                        default:  state_next = S_IDLE;
                    endcase
                end
            S_LOAD_WR:    state_next = S_IDLE;
            S_FRAME_RD:   state_next = S_FRAME_WR;
            S_FRAME_WR:   state_next = last_addr ? S_IDLE : S_FRAME_RD;
            S_APPLY_RD:   state_next = S_APPLY_LD;
            S_APPLY_LD:   state_next = S_APPLY_LANE;
            S_APPLY_LANE:
                if (lane_rsp.done && lane_reg == LANE_LAST)
                    state_next = S_APPLY_WR;
            S_APPLY_WR:   state_next = S_IDLE;
            S_READ_RD:    state_next = S_READ_OUT;
            S_READ_OUT:
                if (out_load)
                    state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        cnt_next       = cnt_reg;
        lane_next      = lane_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        orig_we        = 1'b0;
        cur_we         = 1'b0;
        mark_we        = 1'b0;
        cur_wdata      = work_reg;
        mark_wdata     = MARK_MODIFIED;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                mark_we  = 1'b1;
                cnt_next = last_addr ? '0 : cnt_reg + 1'b1;
            end
            S_LOAD_WR:
            begin
                orig_we = 1'b1;
                mark_we = 1'b1;
            end
            S_FRAME_WR:
            begin
                cnt_next = last_addr ? '0 : cnt_reg + 1'b1;
                if (mark_rd_reg[1])
                begin
                    cur_we     = 1'b1;
                    cur_wdata  = orig_rd_reg;
                    mark_we    = 1'b1;
                    mark_wdata = MARK_ORIG_CUR;
                end
            end
            S_APPLY_LD:
            begin
                lane_next = '0;
                busy_next = 1'b0;
            end
            S_APPLY_LANE:
            begin
                if (!busy_reg)
                    busy_next = 1'b1;
                else if (lane_rsp.done)
                begin
                    busy_next = 1'b0;
                    lane_next = lane_reg + 1'b1;
                end
            end
            S_APPLY_WR:
            begin
                cur_we  = 1'b1;
                mark_we = 1'b1;
            end
            S_READ_OUT:
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    if (mark_rd_reg == MARK_ORIG_CUR)
                    begin
                        mark_we    = 1'b1;
                        mark_wdata = MARK_ORIG_ALL;
                    end
                end
            default:
            begin
            end
        endcase
    end

    // lane selection for the blend unit
    always_comb
    begin
        lane_req.start    = (state_reg == S_APPLY_LANE) && !busy_reg;
        lane_req.is_color = (lane_reg >= LANE_COLOR_FIRST);
        if (lane_req.is_color)
        begin
            lane_req.cur   = {8'd0, work_reg[128 + 8 * lane_reg[1:0] +: 8]};
            lane_req.delta = col_reg[16 * lane_reg[1:0] +: 16];
            lane_active    = act[3];
        end
        else
        begin
            lane_req.cur   = work_reg[16 * lane_reg[2:0] +: 16];
            lane_req.delta = vdelta_reg[16 * lane_reg[2:0] +: 16];
            if (lane_reg < LANE_NORM_FIRST)
                lane_active = act[0];
            else if (lane_reg < LANE_UV_FIRST)
                lane_active = act[1];
            else
                lane_active = act[2];
        end
    end

    bsvm_lane_unit u_lane (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (lane_req),
        .weight (w_reg),
        .rsp    (lane_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            attr_reg      <= ATTR_RESET;
            cnt_reg       <= '0;
            lane_reg      <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            attr_reg      <= attr_next;
            cnt_reg       <= cnt_next;
            lane_reg      <= lane_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request payload and working vertex
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= op;
            vidx_reg   <= vertex_index;
            idx_reg    <= idx_ext[AW-1:0];
            w_reg      <= weight_percent;
            vdelta_reg <= {uv_value, norm_value, pos_value};
            col_reg    <= color_value;
            pm_reg     <= present_mask;
        end
        if (state_reg == S_APPLY_LD)
            work_reg <= cur_rd_reg;
        else if (state_reg == S_APPLY_LANE && busy_reg && lane_rsp.done && lane_active)
        begin
            if (lane_req.is_color)
                work_reg[128 + 8 * lane_reg[1:0] +: 8] <= lane_rsp.result[7:0];
            else
                work_reg[16 * lane_reg[2:0] +: 16] <= lane_rsp.result;
        end
    end

    // vertex stores
    always_ff @(posedge clk)
    begin
        if (orig_we)
            orig_mem[addr] <= {col_reg[31:0], vdelta_reg};
        orig_rd_reg <= orig_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (cur_we)
            cur_mem[addr] <= cur_wdata;
        cur_rd_reg <= cur_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
            mark_mem[addr] <= mark_wdata;
        mark_rd_reg <= mark_mem[addr];
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_vertex_reg <= vidx_reg;
            out_pos_reg    <= attr_reg[0] ? cur_rd_reg[47:0]    : 48'd0;
            out_norm_reg   <= attr_reg[1] ? cur_rd_reg[95:48]   : 48'd0;
            out_uv_reg     <= attr_reg[2] ? cur_rd_reg[127:96]  : 32'd0;
            out_col_reg    <= attr_reg[3] ? cur_rd_reg[159:128] : 32'd0;
            needs_copy_reg <= (mark_rd_reg != MARK_ORIG_ALL);
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_vertex   = out_vertex_reg;
    assign out_position = out_pos_reg;
    assign out_normal   = out_norm_reg;
    assign out_uv       = out_uv_reg;
    assign out_color    = out_col_reg;
    assign needs_copy   = needs_copy_reg;

    a_done_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        lane_rsp.done |-> busy_reg && state_reg == S_APPLY_LANE)
        else $error("blend unit finished with no lane in flight");

    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_READ_OUT) && $past(op_reg == OP_READ))
        else $error("result raised outside a read");

    a_apply_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_APPLY_WR |-> w_reg != 16'sd0 && op_reg == OP_APPLY)
        else $error("apply write-back with zero weight");

endmodule
